// ----- sv/tlbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types, constants and helper functions of the TLB page table
// translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // Default sizes
    localparam int DEF_TLB_DEPTH   = 16;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int DEF_OFFSET_BITS = 8;
    localparam int DEF_FRAME_COUNT = 256;

    // Fixed field widths
    localparam int ADDR_W       = 16;
    localparam int PAGE_OUT_W   = 8;
    localparam int OFFSET_OUT_W = 8;
    localparam int FRAME_OUT_W  = 8;
    localparam int PHYS_W       = 16;
    localparam int LIMIT_W      = 9;
    localparam int STAMP_W      = 32;
    localparam int LFSR_W       = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT   = 1'd1;

    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 9'd256;

    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One step of the Galois LFSR, right shift
    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_MASK;
        end
        return r;
    endfunction

endpackage

// ----- sv/tlbpt_tag_cam.sv -----
// ----------------------------------------------------------------------------
// tlbpt_tag_cam
// Valid bits and page tags of the TLB, with a parallel tag match and a
// first-empty-entry search.
// ----------------------------------------------------------------------------
module tlbpt_tag_cam
    import tlbpt_pkg::*;
#(
    parameter int TLB_DEPTH = DEF_TLB_DEPTH,
    parameter int PAGE_W    = 8,
    localparam int IDX_W    = $clog2(TLB_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [PAGE_W-1:0] wr_tag,
    input  logic [PAGE_W-1:0] lookup_tag,
    output logic              hit,
    output logic [IDX_W-1:0]  hit_idx,
    output logic              full,
    output logic [IDX_W-1:0]  free_idx
);

    logic [TLB_DEPTH-1:0] valid_reg;
    logic [PAGE_W-1:0]    tag_reg [TLB_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_reg[wr_idx] <= wr_tag;
        end
    end

    // Lowest matching index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (valid_reg[i] && tag_reg[i] == lookup_tag) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        full     = &valid_reg;
        free_idx = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

endmodule

// ----- sv/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation through a fully associative TLB
// backed by a one-level page map with on-demand frame allocation.
// ----------------------------------------------------------------------------
// An item that hits the TLB, reads a mapped page, faults in a new frame or
// reports out of frames, or whose refill lands in an empty TLB entry or in a
// pseudo-random victim, passes ST_IDLE (accept the item, read the page map
// and TLB frame/stamp memories) and ST_LOOKUP (decide and write back). A miss
// that refills a full TLB under the least recently used policy also passes
// ST_SCAN and ST_FINISH, since the last-use stamps sit in the TLB memory and
// are scanned one entry per cycle through its single read port. The next
// item is taken once the current one has finished; a result waiting at the
// output holds the finishing cycle until the result slot frees. No clearing
// pass runs after reset: valid bits for the TLB and the page map are flops.
// TLB_DEPTH and PAGE_COUNT must be powers of two.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_DEPTH   = DEF_TLB_DEPTH,
    parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ADDR_W-1:0]       s_logical_address,
    // result items
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [PAGE_OUT_W-1:0]   m_page_index,
    output logic [OFFSET_OUT_W-1:0] m_page_offset,
    output logic                    m_tlb_hit,
    output logic                    m_frame_alloc,
    output logic [FRAME_OUT_W-1:0]  m_frame_index,
    output logic [PHYS_W-1:0]       m_phys_addr,
    output logic                    m_status
);

    localparam int IDX_W   = $clog2(TLB_DEPTH);
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int CNT_W   = FRAME_W + 1;
    localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int WORD_W  = FRAME_W + STAMP_W;
    localparam int SCAN_W  = IDX_W + 1;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic               random_policy_reg;
    logic [LIMIT_W-1:0] frame_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            random_policy_reg <= 1'b0;
            frame_limit_reg   <= FRAME_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RANDOM_POLICY: random_policy_reg <= cfg_wr_data[0];
                REG_FRAME_LIMIT:   frame_limit_reg   <= cfg_wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Control state and per-item registers
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic                   fault_reg;
    logic [SCAN_W-1:0]      scan_k_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [STAMP_W-1:0]     best_stamp_reg;

    logic [CNT_W-1:0]       free_next_reg;
    logic [STAMP_W-1:0]     access_clock_reg;
    logic [LFSR_W-1:0]      lfsr_reg;
    logic [PAGE_COUNT-1:0]  map_valid_reg;

    // Split the incoming address
    logic [31:0]            in_addr32;
    logic [PAGE_W-1:0]      in_page;
    logic [OFFSET_BITS-1:0] in_offset;

    assign in_addr32 = 32'(s_logical_address);
    assign in_page   = PAGE_W'(in_addr32 >> OFFSET_BITS);
    assign in_offset = OFFSET_BITS'(in_addr32);

    // ------------------------------------------------------------------------
    // Tag match
    // ------------------------------------------------------------------------
    logic             cam_wr_en;
    logic [IDX_W-1:0] victim_idx;
    logic             cam_hit;
    logic [IDX_W-1:0] cam_hit_idx;
    logic             cam_full;
    logic [IDX_W-1:0] cam_free_idx;

    tlbpt_tag_cam #(
        .TLB_DEPTH (TLB_DEPTH),
        .PAGE_W    (PAGE_W)
    ) u_tag_cam (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cam_wr_en),
        .wr_idx     (victim_idx),
        .wr_tag     (page_reg),
        .lookup_tag (in_page),
        .hit        (cam_hit),
        .hit_idx    (cam_hit_idx),
        .full       (cam_full),
        .free_idx   (cam_free_idx)
    );

    // ------------------------------------------------------------------------
    // Memories: TLB frame + last-use stamp, and the page map frames
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  tlb_mem [TLB_DEPTH];
    logic [WORD_W-1:0]  tlb_q;
    logic               tlb_rd_en;
    logic [IDX_W-1:0]   tlb_rd_addr;
    logic               tlb_wr_en;
    logic [WORD_W-1:0]  tlb_wr_data;

    logic [FRAME_W-1:0] map_mem [PAGE_COUNT];
    logic [FRAME_W-1:0] map_q;
    logic               map_rd_en;
    logic               map_wr_en;

    always_ff @(posedge aclk) begin
        if (tlb_wr_en) begin
            tlb_mem[victim_idx] <= tlb_wr_data;
        end
        if (tlb_rd_en) begin
            tlb_q <= tlb_mem[tlb_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_wr_en) begin
            map_mem[page_reg] <= free_next_reg[FRAME_W-1:0];
        end
        if (map_rd_en) begin
            map_q <= map_mem[in_page];
        end
    end

    // ------------------------------------------------------------------------
    // Decision logic
    // ------------------------------------------------------------------------
    logic [STAMP_W-1:0] now;
    logic [LFSR_W-1:0]  lfsr_step;
    logic               map_hit;
    logic               frames_gone;
    logic               oof;
    logic               need_scan;
    logic               random_used;
    logic [FRAME_W-1:0] lk_frame;
    logic               lk_fault;
    logic [STAMP_W-1:0] scan_stamp;
    logic               scan_take;
    logic               out_free;

    // Commit signals: one item finishes and writes back
    logic               commit;
    logic               item_hit;
    logic               item_fault;
    logic               item_status;
    logic [FRAME_W-1:0] item_frame;

    assign now         = access_clock_reg + STAMP_W'(1);
    assign lfsr_step   = lfsr_advance(lfsr_reg);
    assign map_hit     = map_valid_reg[page_reg];
    assign frames_gone = (LIM_W'(free_next_reg) >= LIM_W'(frame_limit_reg))
                      || (free_next_reg == CNT_W'(FRAME_COUNT));
    assign oof         = !hit_reg && !map_hit && frames_gone;
    assign need_scan   = !hit_reg && !oof && cam_full && !random_policy_reg;
    assign random_used = !hit_reg && !oof && cam_full && random_policy_reg;
    assign lk_fault    = !hit_reg && !map_hit && !frames_gone;
    assign out_free    = !m_valid || m_ready;

    always_comb begin
        if (hit_reg) begin
            lk_frame = tlb_q[WORD_W-1:STAMP_W];
        end else if (map_hit) begin
            lk_frame = map_q;
        end else begin
            lk_frame = free_next_reg[FRAME_W-1:0];
        end
    end

    // Stamp scan: entry k-1 arrives while entry k is read
    assign scan_stamp = tlb_q[STAMP_W-1:0];
    assign scan_take  = (scan_k_reg == SCAN_W'(1)) || (scan_stamp < best_stamp_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (need_scan) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_k_reg == SCAN_W'(TLB_DEPTH)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready     = 1'b0;
        tlb_rd_en   = 1'b0;
        tlb_rd_addr = cam_hit_idx;
        map_rd_en   = 1'b0;
        commit      = 1'b0;
        item_hit    = 1'b0;
        item_fault  = fault_reg;
        item_status = 1'b0;
        item_frame  = frame_reg;
        victim_idx  = best_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                tlb_rd_en = s_valid;
                map_rd_en = s_valid;
            end
            ST_LOOKUP: begin
                commit      = !need_scan && out_free;
                item_hit    = hit_reg;
                item_fault  = lk_fault;
                item_status = oof;
                item_frame  = lk_frame;
                if (hit_reg) begin
                    victim_idx = hit_idx_reg;
                end else if (!cam_full) begin
                    victim_idx = cam_free_idx;
                end else begin
                    victim_idx = lfsr_step[IDX_W-1:0];
                end
            end
            ST_SCAN: begin
                tlb_rd_en   = scan_k_reg < SCAN_W'(TLB_DEPTH);
                tlb_rd_addr = scan_k_reg[IDX_W-1:0];
            end
            ST_FINISH: begin
                commit = out_free;
            end
            default: ;
        endcase
    end

    assign tlb_wr_en   = commit && !item_status;
    assign tlb_wr_data = {item_frame, now};
    assign cam_wr_en   = commit && !item_status && !item_hit;
    assign map_wr_en   = commit && item_fault;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            free_next_reg    <= '0;
            access_clock_reg <= '0;
            lfsr_reg         <= LFSR_SEED;
            map_valid_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (commit && !item_status) begin
                access_clock_reg <= now;
            end
            // Advance the LFSR only when it actually picks the victim
            if (commit && state_reg == ST_LOOKUP && random_used) begin
                lfsr_reg <= lfsr_step;
            end
            if (map_wr_en) begin
                map_valid_reg[page_reg] <= 1'b1;
                free_next_reg           <= free_next_reg + CNT_W'(1);
            end
        end
    end

    // Per-item payload, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            page_reg    <= in_page;
            offset_reg  <= in_offset;
            hit_reg     <= cam_hit;
            hit_idx_reg <= cam_hit_idx;
        end
        if (state_reg == ST_LOOKUP) begin
            frame_reg  <= lk_frame;
            fault_reg  <= lk_fault;
            scan_k_reg <= '0;
        end
        if (state_reg == ST_SCAN) begin
            scan_k_reg <= scan_k_reg + SCAN_W'(1);
            if (scan_k_reg != '0 && scan_take) begin
                best_idx_reg   <= IDX_W'(scan_k_reg - SCAN_W'(1));
                best_stamp_reg <= scan_stamp;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [31:0] phys_sum;

    assign phys_sum = (32'(item_frame) << OFFSET_BITS) + 32'(offset_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (commit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_page_index  <= PAGE_OUT_W'(page_reg);
            m_page_offset <= OFFSET_OUT_W'(offset_reg);
            m_tlb_hit     <= item_hit;
            m_frame_alloc <= item_fault;
            m_frame_index <= item_status ? '0 : FRAME_OUT_W'(item_frame);
            m_phys_addr   <= item_status ? '0 : phys_sum[PHYS_W-1:0];
            m_status      <= item_status;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_free_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        free_next_reg <= CNT_W'(FRAME_COUNT))
        else $error("free frame counter beyond frame count");

    a_fault_maps: assert property (@(posedge aclk) disable iff (!aresetn)
        map_wr_en |=> map_valid_reg[$past(page_reg)])
        else $error("faulted page not marked mapped");

    a_oof_no_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && item_status |=> $stable(access_clock_reg) && $stable(lfsr_reg))
        else $error("out of frames item changed state");

    a_scan_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cam_full && !random_policy_reg)
        else $error("stamp scan without a full LRU TLB");

    a_commit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!m_valid || m_ready))
        else $error("result overwrote a waiting item");

endmodule

// ----- tb/tlbpt_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpt_tb_pkg
// Translation scoreboard: keeps a private copy of the TLB, the page map and
// the frame allocator, predicts every result item and checks the block's.
// ----------------------------------------------------------------------------
package tlbpt_tb_pkg;
    import tlbpt_pkg::*;

    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    localparam logic XLATE_OK       = 1'b0;
    localparam logic XLATE_NO_FRAME = 1'b1;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0]   page_index;
        logic [OFFSET_OUT_W-1:0] page_offset;
        logic                    tlb_hit;
        logic                    frame_alloc;
        logic [FRAME_OUT_W-1:0]  frame_index;
        logic [PHYS_W-1:0]       phys_addr;
        logic                    status;
    } xlate_t;

    class xlate_scoreboard;
        logic                   policy;
        logic [LIMIT_W-1:0]     frame_limit;
        logic                   tlb_valid [DEF_TLB_DEPTH];
        logic [PAGE_OUT_W-1:0]  tlb_tag   [DEF_TLB_DEPTH];
        logic [FRAME_OUT_W-1:0] tlb_frame [DEF_TLB_DEPTH];
        logic [STAMP_W-1:0]     tlb_stamp [DEF_TLB_DEPTH];
        logic                   map_valid [DEF_PAGE_COUNT];
        logic [FRAME_OUT_W-1:0] map_frame [DEF_PAGE_COUNT];
        logic [LIMIT_W-1:0]     next_free;
        logic [STAMP_W-1:0]     access_clock;
        logic [LFSR_W-1:0]      victim_lfsr;
        xlate_t                 expected_xlate [$];
        int errors, matched, hits, faults, no_frame, lru_evictions, random_evictions;

        function new();
            policy       = POLICY_LRU;
            frame_limit  = FRAME_LIMIT_RESET;
            foreach (tlb_valid[i]) begin
                tlb_valid[i] = 1'b0;
                tlb_stamp[i] = '0;
            end
            foreach (map_valid[i]) map_valid[i] = 1'b0;
            next_free    = '0;
            access_clock = '0;
            victim_lfsr  = LFSR_SEED;
            errors = 0; matched = 0; hits = 0; faults = 0; no_frame = 0;
            lru_evictions = 0; random_evictions = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RANDOM_POLICY: policy = data[0];
                REG_FRAME_LIMIT:   frame_limit = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_xlate.size();
        endfunction

        // Predict the result of one accepted access and update the state.
        function void note_access(logic [ADDR_W-1:0] addr);
            logic [PAGE_OUT_W-1:0]  page;
            logic [OFFSET_OUT_W-1:0] offset;
            logic [FRAME_OUT_W-1:0] frame;
            logic [STAMP_W-1:0]     now;
            int                     limit;
            int                     slot;
            bit                     found;
            xlate_t                 r;
            page   = PAGE_OUT_W'((addr >> DEF_OFFSET_BITS) % DEF_PAGE_COUNT);
            offset = OFFSET_OUT_W'(addr & ((1 << DEF_OFFSET_BITS) - 1));
            now    = access_clock + 1;
            limit  = (frame_limit < DEF_FRAME_COUNT) ? frame_limit : DEF_FRAME_COUNT;
            frame  = '0;
            found  = 1'b0;
            r      = '0;
            r.page_index  = page;
            r.page_offset = offset;
            r.status      = XLATE_OK;

            for (int i = 0; i < DEF_TLB_DEPTH; i++) begin
                if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
                    tlb_stamp[i] = now;
                    frame = tlb_frame[i];
                    found = 1'b1;
                end
            end

            if (found) begin
                r.tlb_hit = 1'b1;
                hits++;
            end else if (map_valid[page]) begin
                frame = map_frame[page];
            end else if (next_free >= limit) begin
                r.status = XLATE_NO_FRAME;
                no_frame++;
            end else begin
                frame = FRAME_OUT_W'(next_free);
                map_valid[page] = 1'b1;
                map_frame[page] = frame;
                next_free++;
                r.frame_alloc = 1'b1;
                faults++;
            end

            if (r.status == XLATE_OK) begin
                access_clock = now;
                if (!found) begin
                    // empty entry first, then the victim of the active policy
                    slot = -1;
                    for (int i = 0; i < DEF_TLB_DEPTH; i++)
                        if (slot < 0 && !tlb_valid[i]) slot = i;
                    if (slot < 0 && policy == POLICY_RANDOM) begin
                        victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? LFSR_MASK : '0);
                        slot = victim_lfsr % DEF_TLB_DEPTH;
                        random_evictions++;
                    end else if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < DEF_TLB_DEPTH; i++)
                            if (tlb_stamp[i] < tlb_stamp[slot]) slot = i;
                        lru_evictions++;
                    end
                    tlb_valid[slot] = 1'b1;
                    tlb_tag[slot]   = page;
                    tlb_frame[slot] = frame;
                    tlb_stamp[slot] = now;
                end
                r.frame_index = frame;
                r.phys_addr   = PHYS_W'((32'(frame) << DEF_OFFSET_BITS) + 32'(offset));
            end
            expected_xlate.push_back(r);
        endfunction

        function void check_field(string name, logic [PHYS_W-1:0] want, logic [PHYS_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(xlate_t got);
            xlate_t want;
            if (expected_xlate.size() == 0) begin
                $error("result item with no access pending: page 0x%0h", got.page_index);
                errors++;
                return;
            end
            want = expected_xlate.pop_front();
            check_field("page_index",  want.page_index,  got.page_index);
            check_field("page_offset", want.page_offset, got.page_offset);
            check_field("tlb_hit",     want.tlb_hit,     got.tlb_hit);
            check_field("frame_alloc", want.frame_alloc, got.frame_alloc);
            check_field("frame_index", want.frame_index, got.frame_index);
            check_field("phys_addr",   want.phys_addr,   got.phys_addr);
            check_field("status",      want.status,      got.status);
            matched++;
        endfunction
    endclass

endpackage

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression for the TLB page table translator: a directed opening on the
// address extremes, frame exhaustion and TLB hits, then random phases over a
// drifting set of hot pages under both victim policies and a range of frame
// limits, with random pacing on both channels.
// ----------------------------------------------------------------------------
module tb;
    import tlbpt_pkg::*;
    import tlbpt_tb_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 5;
    // worst item: LRU scan of a full TLB
    localparam int DRAIN_CYCLES = DEF_TLB_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOT_PAGES    = 32;

    logic                    aclk              = 1'b0;
    logic                    aresetn           = 1'b0;
    logic                    cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr          = REG_RANDOM_POLICY;
    logic [CFG_DATA_W-1:0]   cfg_wr_data       = '0;
    logic                    s_valid           = 1'b0;
    logic                    s_ready;
    logic [ADDR_W-1:0]       s_logical_address = '0;
    logic                    m_valid;
    logic                    m_ready           = 1'b0;
    logic [PAGE_OUT_W-1:0]   m_page_index;
    logic [OFFSET_OUT_W-1:0] m_page_offset;
    logic                    m_tlb_hit;
    logic                    m_frame_alloc;
    logic [FRAME_OUT_W-1:0]  m_frame_index;
    logic [PHYS_W-1:0]       m_phys_addr;
    logic                    m_status;

    xlate_scoreboard         sb;
    int unsigned             cycle_count   = 0;
    bit                      pace_items    = 1'b1;
    bit                      stall_results = 1'b1;
    logic [PAGE_OUT_W-1:0]   hot_pages [HOT_PAGES];

    always #HALF_PERIOD aclk = ~aclk;

    tlb_page_table_translator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_logical_address (s_logical_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_page_index      (m_page_index),
        .m_page_offset     (m_page_offset),
        .m_tlb_hit         (m_tlb_hit),
        .m_frame_alloc     (m_frame_alloc),
        .m_frame_index     (m_frame_index),
        .m_phys_addr       (m_phys_addr),
        .m_status          (m_status)
    );

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tlb_page_table_translator regression: fail");
            $finish;
        end
    end

    // Present one access. Called and returning at a falling edge; valid stays
    // high on return so that a zero gap keeps the next item back to back.
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = pace_items ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_logical_address <= addr;
        // hold valid and address until the block takes the item
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_access(addr);
        @(negedge aclk);
    endtask

    // Drop valid after the last item of a burst.
    task automatic end_burst();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every expected result has come back and the block is idle.
    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write both registers while idle; the policy write carries junk in the
    // unused upper data bits.
    task automatic write_config(input logic policy, input logic [LIMIT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] data;
        wait_drained();
        data = CFG_DATA_W'($urandom);
        data[0] = policy;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_RANDOM_POLICY;
        cfg_wr_data <= data;
        sb.set_reg(REG_RANDOM_POLICY, data);
        @(negedge aclk);
        cfg_addr    <= REG_FRAME_LIMIT;
        cfg_wr_data <= limit;
        sb.set_reg(REG_FRAME_LIMIT, limit);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // One random phase: accesses hit a hot page set larger than the TLB, except a
    // noise_pct share of arbitrary addresses that push frame allocation along.
    task automatic run_phase(input logic policy, input logic [LIMIT_W-1:0] limit,
                             input int n_items, input int noise_pct,
                             input bit pace, input bit stall);
        logic [ADDR_W-1:0]       addr;
        logic [OFFSET_OUT_W-1:0] offs;
        write_config(policy, limit);
        pace_items    = pace;
        stall_results = stall;
        // let the working set drift a little
        repeat (8) hot_pages[$urandom_range(0, HOT_PAGES - 1)] = PAGE_OUT_W'($urandom);
        repeat (n_items) begin
            offs = OFFSET_OUT_W'($urandom);
            if ($urandom_range(0, 99) < noise_pct)
                addr = ADDR_W'($urandom);
            else
                addr = {hot_pages[$urandom_range(0, HOT_PAGES - 1)], offs};
            send_access(addr);
        end
        end_burst();
    endtask

    // Result side: draw a stall per item, then hold ready until a result
    // item is taken and check it.
    initial begin
        int     stall;
        xlate_t seen;
        @(negedge aclk);
        forever begin
            stall = stall_results ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            seen.page_index  = m_page_index;
            seen.page_offset = m_page_offset;
            seen.tlb_hit     = m_tlb_hit;
            seen.frame_alloc = m_frame_alloc;
            seen.frame_index = m_frame_index;
            seen.phys_addr   = m_phys_addr;
            seen.status      = m_status;
            sb.check_result(seen);
            @(negedge aclk);
        end
    end

    initial begin
        sb = new();
        foreach (hot_pages[i]) hot_pages[i] = PAGE_OUT_W'($urandom);
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No frames at all: every new page runs out of frames.
        write_config(POLICY_LRU, 0);
        send_access(16'h1234);
        send_access(16'hFFFF);
        send_access(16'h0000);
        end_burst();

        // Three frames: faults on the address extremes and a middle page, TLB hits on
        // the same pages, and a fourth page that finds no frame left.
        write_config(POLICY_LRU, 3);
        send_access(16'h0000);
        send_access(16'h00FF);
        send_access(16'hFFFF);
        send_access(16'hFF00);
        send_access(16'h8001);
        send_access(16'h7FFE);
        send_access(16'h0080);
        send_access(16'h8080);
        send_access(16'h7F01);
        end_burst();

        // Random phases: both policies, small and over-range limits, and
        // every mix of pacing on the two channels.
        run_phase(POLICY_LRU,     24,  120, 10, 1'b1, 1'b1);
        run_phase(POLICY_RANDOM,  48,  120, 10, 1'b0, 1'b0);
        run_phase(POLICY_LRU,     511, 120, 20, 1'b1, 1'b0);
        run_phase(POLICY_RANDOM,  256, 120, 30, 1'b0, 1'b1);
        run_phase(POLICY_LRU,     1,   60,  20, 1'b1, 1'b1);
        run_phase(POLICY_RANDOM,  300, 160, 50, 1'b1, 1'b1);

        // Drain and give a stray result time to show up.
        wait_drained();

        $display("Translated %0d accesses: %0d TLB hits, %0d page faults, %0d out of frames.",
                 sb.matched, sb.hits, sb.faults, sb.no_frame);
        $display("TLB refills evicted %0d by LRU and %0d by LFSR; %0d frames handed out.",
                 sb.lru_evictions, sb.random_evictions, sb.next_free);
        if (sb.errors == 0)
            $display("tlb_page_table_translator regression: pass");
        else
            $display("tlb_page_table_translator regression: fail");
        $finish;
    end

endmodule
